### src/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg : shared types and constants of the keyed record table
// operation and status codes, field widths and the cell control bundle
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int KEY_W    = 31;
    localparam int NAME_W   = 64;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_UPDATE = 3'd1,
        OP_DELETE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_LIST   = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_KEY   = 3'd1,
        ST_FULL      = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_UNCHANGED = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic              cmp;       // capture key match
        logic              append;    // write key and name into first free cell
        logic              set_name;  // overwrite name of matching cell
        logic              shift;     // close the gap left by a delete
        logic              rotate;    // list walk: records move down one cell, the head record goes to the tail
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
    } t_cell_ctl;

endpackage

### src/krt_if.sv
// ----------------------------------------------------------------------------
// krt interfaces : request and response channels of the keyed record table
// valid/ready handshake with the payload fields of one transaction
// ----------------------------------------------------------------------------
interface krt_req_if import krt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name_value;

    modport source (output valid, output operation, output key, output name_value,
                    input ready);
    modport sink   (input valid, input operation, input key, input name_value,
                    output ready);
endinterface

interface krt_rsp_if import krt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    entry_key;
    logic [NAME_W-1:0]   entry_name;
    logic [POS_W-1:0]    position;
    logic                last;

    modport source (output valid, output status, output entry_key, output entry_name,
                    output position, output last, input ready);
    modport sink   (input valid, input status, input entry_key, input entry_name,
                    input position, input last, output ready);
endinterface

### src/keyed_record_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_record_table_unit : keyed record table built as a chain of cells
// add, update, delete, search and list over up to TABLE_DEPTH records kept
// in insertion order, one record per cell
// ----------------------------------------------------------------------------
// channel  | dir | transaction payload
// ---------+-----+-----------------------------------------------------------
// i_req    | in  | operation, key, name_value
// o_rsp    | out | status, entry_key, entry_name, position, last
//
// add, update, delete and search step through accept, key compare in every
// cell, match reduction, result and table write
// list runs the same steps, then the chain rotates by one cell a cycle unless
// o_rsp stalls and cell 0 feeds the output, so the order is restored at the end
// unknown operation codes are accepted and give no transaction
// i_rst_n empties the table; record contents are not cleared
// a stalled o_rsp holds the result register and freezes the sequencer before
// its next result; a new request is taken while a result waits
// ----------------------------------------------------------------------------
module keyed_record_table_unit import krt_pkg::*; #(
    parameter int TABLE_DEPTH = 32,
    parameter int NAME_BITS   = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    krt_req_if.sink  i_req,
    krt_rsp_if.source o_rsp
);

    localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_RES  = 5'b00100,
        S_EXEC = 5'b01000,
        S_LIST = 5'b10000
    } t_state;

    // sequencer state
    t_state               r_state, n_state;
    t_op                  r_op;
    logic [KEY_W-1:0]     r_key;
    logic [NAME_BITS-1:0] r_name;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IW-1:0]        r_idx, n_idx;

    // reduced match result
    logic                 r_hit, hit;
    logic [IW-1:0]        r_hit_pos, hit_pos;
    logic [NAME_BITS-1:0] r_hit_name, hit_name;

    // result register
    logic                 r_out_valid;
    t_status              r_status, n_status;
    logic [KEY_W-1:0]     r_out_key, n_out_key;
    logic [NAME_BITS-1:0] r_out_name, n_out_name;
    logic [POS_W-1:0]     r_out_pos, n_out_pos;
    logic                 r_out_last, n_out_last;
    logic                 load_out;
    logic                 out_free;

    // chain
    t_cell_ctl            cell_ctl;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH:0]   after_chain;
    logic [KEY_W-1:0]     cell_key  [TABLE_DEPTH];
    logic [NAME_BITS-1:0] cell_name [TABLE_DEPTH];

    logic                 op_known;
    logic                 full;
    logic                 key_zero;
    logic                 list_last;

    assign after_chain[0] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0]     next_key;
        logic [NAME_BITS-1:0] next_name;

        // the end cell has no neighbour and keeps its own record
        if (g == TABLE_DEPTH - 1) begin : g_end
            assign next_key  = cell_key[g];
            assign next_name = cell_name[g];
        end else begin : g_mid
            assign next_key  = cell_key[g+1];
            assign next_name = cell_name[g+1];
        end

        krt_cell #(
            .NAME_BITS (NAME_BITS),
            .CNT_W     (CNT_W),
            .IDX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_count     (r_count),
            .i_next_key  (next_key),
            .i_next_name (next_name),
            .i_head_key  (cell_key[0]),
            .i_head_name (cell_name[0]),
            .i_after     (after_chain[g]),
            .o_after     (after_chain[g+1]),
            .o_match     (match_vec[g]),
            .o_key       (cell_key[g]),
            .o_name      (cell_name[g])
        );
    end

    // keys are unique, so at most one match line is set and an or suffices
    always_comb begin
        hit      = 1'b0;
        hit_pos  = '0;
        hit_name = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit      = hit | match_vec[i];
            hit_pos  = hit_pos | (match_vec[i] ? IW'(i) : '0);
            hit_name = hit_name | (match_vec[i] ? cell_name[i] : '0);
        end
    end

    assign op_known = (i_req.operation == OP_ADD)    || (i_req.operation == OP_UPDATE) ||
                      (i_req.operation == OP_DELETE) || (i_req.operation == OP_SEARCH) ||
                      (i_req.operation == OP_LIST);
    assign full      = r_count >= CNT_W'(TABLE_DEPTH);
    assign key_zero  = r_key == '0;
    assign list_last = CNT_W'(r_idx) == (r_count - CNT_W'(1));
    assign out_free  = !r_out_valid || o_rsp.ready;

    assign i_req.ready = r_state == S_IDLE;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        cell_ctl      = '0;
        cell_ctl.key  = r_key;
        cell_ctl.name = NAME_W'(r_name);
        load_out      = 1'b0;
        n_status      = ST_OK;
        n_out_key     = r_key;
        n_out_name    = '0;
        n_out_pos     = '0;
        n_out_last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid && op_known) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                cell_ctl.cmp = 1'b1;
                n_state      = S_RES;
            end
            S_RES: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    case (r_op)
                        OP_ADD: begin
                            // a full table is reported before the key is looked at
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (key_zero) begin
                                n_status = ST_BAD_KEY;
                            end else if (r_hit) begin
                                n_status   = ST_DUPLICATE;
                                n_out_name = r_hit_name;
                                n_out_pos  = POS_W'(r_hit_pos);
                            end else begin
                                n_out_name      = r_name;
                                n_out_pos       = POS_W'(r_count);
                                cell_ctl.append = 1'b1;
                                n_count         = r_count + CNT_W'(1);
                            end
                        end
                        OP_UPDATE: begin
                            if (key_zero) begin
                                n_status = ST_BAD_KEY;
                            end else if (!r_hit) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_out_name = r_name;
                                n_out_pos  = POS_W'(r_hit_pos);
                                if (r_hit_name == r_name) begin
                                    n_status = ST_UNCHANGED;
                                end else begin
                                    cell_ctl.set_name = 1'b1;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (key_zero) begin
                                n_status = ST_BAD_KEY;
                            end else if (!r_hit) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_out_name     = r_hit_name;
                                n_out_pos      = POS_W'(r_hit_pos);
                                cell_ctl.shift = 1'b1;
                                n_count        = r_count - CNT_W'(1);
                            end
                        end
                        OP_SEARCH: begin
                            if (key_zero) begin
                                n_status = ST_BAD_KEY;
                            end else if (!r_hit) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_out_name = r_hit_name;
                                n_out_pos  = POS_W'(r_hit_pos);
                            end
                        end
                        OP_LIST: begin
                            n_out_key = '0;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // records are emitted from the list walk instead
                                load_out = 1'b0;
                                n_idx    = '0;
                                n_state  = S_LIST;
                            end
                        end
                        default: begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (out_free) begin
                    load_out        = 1'b1;
                    cell_ctl.rotate = 1'b1;
                    n_out_key       = cell_key[0];
                    n_out_name      = cell_name[0];
                    n_out_pos       = POS_W'(r_idx);
                    n_out_last      = list_last;
                    n_idx           = r_idx + IW'(1);
                    if (list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready && op_known) begin
            r_op   <= t_op'(i_req.operation);
            r_key  <= i_req.key;
            r_name <= i_req.name_value[NAME_BITS-1:0];
        end
        if (r_state == S_RES) begin
            r_hit      <= hit;
            r_hit_pos  <= hit_pos;
            r_hit_name <= hit_name;
        end
        r_idx <= n_idx;
        if (load_out) begin
            r_status   <= n_status;
            r_out_key  <= n_out_key;
            r_out_name <= n_out_name;
            r_out_pos  <= n_out_pos;
            r_out_last <= n_out_last;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.entry_key  = r_out_key;
    assign o_rsp.entry_name = NAME_W'(r_out_name);
    assign o_rsp.position   = r_out_pos;
    assign o_rsp.last       = r_out_last;

    // occupancy never runs past the chain length
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("record count beyond table depth");

    // unique keys leave at most one match line set
    a_single_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // a successful add grows the table by exactly one record
    a_add_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_state == S_EXEC && r_op == OP_ADD && n_status == ST_OK)
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("add did not grow the table");

    // the list walk only runs over a non-empty table and within it
    a_list_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_count != '0) && (CNT_W'(r_idx) < r_count))
        else $error("list walk outside the stored records");

endmodule

### src/krt_cell.sv
// ----------------------------------------------------------------------------
// krt_cell : one record slot of the table chain
// holds a key and a name, matches a broadcast key; the tail cell takes the
// head record on a rotation, others their neighbour's on a shift or a rotation
// ----------------------------------------------------------------------------
module krt_cell import krt_pkg::*; #(
    parameter int NAME_BITS = 64,
    parameter int CNT_W     = 6,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [KEY_W-1:0]     i_next_key,
    input  logic [NAME_BITS-1:0] i_next_name,
    input  logic [KEY_W-1:0]     i_head_key,
    input  logic [NAME_BITS-1:0] i_head_name,
    input  logic                 i_after,
    output logic                 o_after,
    output logic                 o_match,
    output logic [KEY_W-1:0]     o_key,
    output logic [NAME_BITS-1:0] o_name
);

    logic [KEY_W-1:0]     r_key;
    logic [NAME_BITS-1:0] r_name;
    logic                 r_match;
    logic                 occupied;
    logic                 tail;
    logic                 free_slot;

    assign occupied  = CNT_W'(IDX) < i_count;
    assign tail      = CNT_W'(IDX + 1) == i_count;
    assign free_slot = CNT_W'(IDX) == i_count;

    // cells from the match onwards take part in a delete shift
    assign o_after = i_after | r_match;
    assign o_match = r_match;
    assign o_key   = r_key;
    assign o_name  = r_name;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= occupied && (r_key == i_ctl.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.append && free_slot) begin
            r_key  <= i_ctl.key;
            r_name <= i_ctl.name[NAME_BITS-1:0];
        end else if (i_ctl.set_name && r_match) begin
            r_name <= i_ctl.name[NAME_BITS-1:0];
        end else if (i_ctl.shift && o_after) begin
            r_key  <= i_next_key;
            r_name <= i_next_name;
        end else if (i_ctl.rotate && tail) begin
            r_key  <= i_head_key;
            r_name <= i_head_name;
        end else if (i_ctl.rotate && occupied) begin
            r_key  <= i_next_key;
            r_name <= i_next_name;
        end
    end

endmodule

### tb/tb_keyed_record_table_unit.sv
// ----------------------------------------------------------------------------
// tb_keyed_record_table_unit : self-checking bench of the keyed record table
// a queue of pending requests feeds a clocked driver, and a clocked monitor
// checks every response against an in-bench model of the record table.
// a directed opening covers empty, invalid, duplicate, unchanged and unknown
// cases, then random fill, mix and drain phases push the table to full and
// back, with random idle bursts on both channels
// ----------------------------------------------------------------------------
module tb_keyed_record_table_unit;
    import krt_pkg::*;

    localparam int DEPTH        = 32;
    localparam int POOL_SIZE    = 48;      // recurring keys, so hits and duplicates are common
    localparam int RANDOM_ITEMS = 450;
    localparam int PHASE_LEN    = 75;
    localparam int QUIET_TAIL   = 60;      // last requests go through with no idling
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
    } t_req_item;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [NAME_W-1:0]   name;
        logic [POS_W-1:0]    pos;
        logic                last;
    } t_rsp_item;

    logic i_clk;
    logic i_rst_n;

    krt_req_if req_ch ();
    krt_rsp_if rsp_ch ();

    keyed_record_table_unit #(
        .TABLE_DEPTH (DEPTH),
        .NAME_BITS   (NAME_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // clock, period 10
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // requests waiting to be driven, and responses the table model has promised
    t_req_item req_pending[$];
    t_rsp_item rsp_expected[$];

    // table model: records kept in slots 0 .. rec_count-1 in insertion order
    logic [KEY_W-1:0]  rec_keys  [DEPTH];
    logic [NAME_W-1:0] rec_names [DEPTH];
    int                rec_count;

    // key pool for the random part, each key with a usual name so updates can repeat it
    logic [KEY_W-1:0]  key_pool  [POOL_SIZE];
    logic [NAME_W-1:0] base_name [POOL_SIZE];

    // bookkeeping
    int        errors;
    int        accepted;
    int        responses;
    int        cycle_count;
    int        peak_count;
    int        op_count [8];
    logic [7:0] status_seen;

    // driver and ready generator state
    logic req_taken;
    int   req_gap;
    int   rsp_stall;

    // ------------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------------
    function automatic void push_rsp(input logic [STATUS_W-1:0] st, input logic [KEY_W-1:0] k,
                                     input logic [NAME_W-1:0] n, input int pos,
                                     input logic lst);
        t_rsp_item r;
        r.status = st;
        r.key    = k;
        r.name   = n;
        r.pos    = pos[POS_W-1:0];
        r.last   = lst;
        rsp_expected.push_back(r);
        status_seen[st] = 1'b1;
    endfunction

    function automatic void model_record_op(input t_req_item it);
        int slot;
        logic [NAME_W-1:0] old_name;
        // list walks every record, or answers empty on an empty table
        if (it.op == OP_LIST) begin
            if (rec_count == 0) begin
                push_rsp(ST_EMPTY, '0, '0, 0, 1'b1);
            end else begin
                for (int i = 0; i < rec_count; i++) begin
                    push_rsp(ST_OK, rec_keys[i], rec_names[i], i, (i + 1 == rec_count));
                end
            end
            return;
        end
        // unknown codes give nothing
        if (it.op > OP_LIST) begin
            return;
        end
        // a full table refuses an add before the key is looked at
        if (it.op == OP_ADD && rec_count >= DEPTH) begin
            push_rsp(ST_FULL, it.key, '0, 0, 1'b1);
            return;
        end
        if (it.key == '0) begin
            push_rsp(ST_BAD_KEY, it.key, '0, 0, 1'b1);
            return;
        end
        slot = rec_count;
        for (int i = 0; i < rec_count; i++) begin
            if (rec_keys[i] == it.key && slot == rec_count) begin
                slot = i;
            end
        end
        if (it.op == OP_ADD) begin
            if (slot < rec_count) begin
                push_rsp(ST_DUPLICATE, it.key, rec_names[slot], slot, 1'b1);
            end else begin
                rec_keys[slot]  = it.key;
                rec_names[slot] = it.name;
                rec_count       = slot + 1;
                if (rec_count > peak_count) begin
                    peak_count = rec_count;
                end
                push_rsp(ST_OK, it.key, it.name, slot, 1'b1);
            end
            return;
        end
        if (slot >= rec_count) begin
            push_rsp(ST_NOT_FOUND, it.key, '0, 0, 1'b1);
            return;
        end
        case (it.op)
            OP_UPDATE: begin
                if (rec_names[slot] == it.name) begin
                    push_rsp(ST_UNCHANGED, it.key, it.name, slot, 1'b1);
                end else begin
                    rec_names[slot] = it.name;
                    push_rsp(ST_OK, it.key, it.name, slot, 1'b1);
                end
            end
            OP_DELETE: begin
                // later records close up the gap
                old_name = rec_names[slot];
                for (int j = slot; j + 1 < rec_count; j++) begin
                    rec_keys[j]  = rec_keys[j + 1];
                    rec_names[j] = rec_names[j + 1];
                end
                rec_count--;
                push_rsp(ST_OK, it.key, old_name, slot, 1'b1);
            end
            default: begin
                push_rsp(ST_OK, it.key, rec_names[slot], slot, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                                      input logic [NAME_W-1:0] n);
        t_req_item it;
        it.op   = op;
        it.key  = k;
        it.name = n;
        req_pending.push_back(it);
    endfunction

    // phases: fill, fill, mix, drain, fill, drain
    function automatic t_req_item make_random_req(input int phase);
        t_req_item it;
        int idx;
        int pick;
        int w_add;
        int w_del;
        idx     = $urandom_range(0, POOL_SIZE - 1);
        it.key  = key_pool[idx];
        it.name = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} : base_name[idx];
        case (phase)
            0, 1, 4: begin
                w_add = 55;
                w_del = 8;
            end
            2: begin
                w_add = 30;
                w_del = 20;
            end
            default: begin
                w_add = 12;
                w_del = 45;
            end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < w_add) begin
            it.op = OP_ADD;
        end else if (pick < w_add + 12) begin
            it.op = OP_UPDATE;
        end else if (pick < w_add + 12 + w_del) begin
            it.op = OP_DELETE;
        end else if (pick < w_add + 24 + w_del) begin
            it.op = OP_SEARCH;
        end else if (pick < w_add + 29 + w_del) begin
            it.op = OP_LIST;
        end else begin
            // noise: zero key, unknown code, or a key from the whole range
            case ($urandom_range(0, 2))
                0: begin
                    it.op  = OP_W'($urandom_range(OP_ADD, OP_SEARCH));
                    it.key = '0;
                end
                1: begin
                    it.op   = OP_W'($urandom_range(5, 7));
                    it.key  = KEY_W'($urandom);
                    it.name = {$urandom, $urandom};
                end
                default: begin
                    it.op  = OP_W'($urandom_range(OP_ADD, OP_SEARCH));
                    it.key = KEY_W'($urandom);
                end
            endcase
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: changes on the falling edge, holds an offered
    // transaction until it is taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic      nxt_valid;
        logic      quiet;
        t_req_item it;
        nxt_valid = req_ch.valid;
        quiet     = (req_pending.size() < QUIET_TAIL) || ((accepted / 50) % 3 == 2);
        if (i_rst_n) begin
            if (!req_ch.valid || req_taken) begin
                nxt_valid = 1'b0;
                if (req_gap > 0) begin
                    req_gap--;
                end else if (req_pending.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        // idle burst whose length is drawn at random, starting now
                        req_gap = $urandom_range(1, 8) - 1;
                    end else begin
                        it                   = req_pending.pop_front();
                        nxt_valid            = 1'b1;
                        req_ch.operation  <= it.op;
                        req_ch.key        <= it.key;
                        req_ch.name_value <= it.name;
                    end
                end
            end
        end
        req_ch.valid <= nxt_valid;
    end

    // response back-pressure in bursts
    always @(negedge i_clk) begin
        logic nxt_ready;
        logic quiet;
        quiet     = (req_pending.size() < QUIET_TAIL) || ((accepted / 50) % 3 == 1);
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (rsp_stall > 0) begin
                rsp_stall--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp_stall = $urandom_range(1, 8) - 1;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        rsp_ch.ready <= nxt_ready;
    end

    // ------------------------------------------------------------------------
    // monitor: model every accepted request, check every accepted response
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_req_item it;
        t_rsp_item got;
        t_rsp_item want;
        req_taken <= req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            it.op   = req_ch.operation;
            it.key  = req_ch.key;
            it.name = req_ch.name_value;
            model_record_op(it);
            op_count[it.op]++;
            accepted++;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.status = rsp_ch.status;
            got.key    = rsp_ch.entry_key;
            got.name   = rsp_ch.entry_name;
            got.pos    = rsp_ch.position;
            got.last   = rsp_ch.last;
            responses++;
            if (rsp_expected.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected transaction: st=%0d key=%h name=%h pos=%0d last=%0b",
                             got.status, got.key, got.name, got.pos, got.last);
                end
            end else begin
                want = rsp_expected.pop_front();
                if (got.status !== want.status || got.key !== want.key ||
                    got.name !== want.name || got.pos !== want.pos ||
                    got.last !== want.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at response %0d", responses);
                        $display("  expected st=%0d key=%h name=%h pos=%0d last=%0b",
                                 want.status, want.key, want.name, want.pos, want.last);
                        $display("  actual   st=%0d key=%h name=%h pos=%0d last=%0b",
                                 got.status, got.key, got.name, got.pos, got.last);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, rsp_expected.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [KEY_W-1:0] k_mid;
        logic [KEY_W-1:0] k_max;
        // every input known from the start
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_ADD;
        req_ch.key        = '0;
        req_ch.name_value = '0;
        rsp_ch.ready      = 1'b0;
        req_taken         = 1'b0;
        req_gap           = 0;
        rsp_stall         = 0;
        rec_count         = 0;
        errors            = 0;
        accepted          = 0;
        responses         = 0;
        cycle_count       = 0;
        peak_count        = 0;
        status_seen       = '0;
        for (int i = 0; i < 8; i++) begin
            op_count[i] = 0;
        end
        i_rst_n = 1'b0;

        k_max = '1;
        k_mid = 31'h2AAA_AAAA;

        // directed opening: empty table, zero key, extremes, duplicate,
        // unchanged update, shifting delete, unknown codes
        queue_req(OP_LIST,   '0, '0);
        queue_req(OP_SEARCH, 31'd5, '0);
        queue_req(OP_DELETE, 31'd5, '0);
        queue_req(OP_UPDATE, 31'd5, 64'h1234);
        queue_req(OP_ADD,    '0, 64'hDEAD_BEEF);
        queue_req(OP_UPDATE, '0, 64'h1);
        queue_req(OP_DELETE, '0, '0);
        queue_req(OP_SEARCH, '0, '0);
        queue_req(OP_ADD,    31'd1, '0);
        queue_req(OP_ADD,    k_max, '1);
        queue_req(OP_ADD,    k_mid, 64'hA5A5_A5A5_5A5A_5A5A);
        queue_req(OP_ADD,    31'd1, 64'h77);
        queue_req(OP_UPDATE, k_max, '1);
        queue_req(OP_UPDATE, 31'd1, 64'h5555_5555_5555_5555);
        queue_req(OP_SEARCH, k_mid, '0);
        queue_req(OP_LIST,   k_max, '1);
        queue_req(OP_DELETE, 31'd1, '0);
        queue_req(OP_SEARCH, k_max, '0);
        queue_req(3'd5,      k_max, '1);
        queue_req(3'd6,      31'd1, 64'h1);
        queue_req(3'd7,      '0, '0);
        queue_req(OP_DELETE, k_mid, '0);
        queue_req(OP_LIST,   '0, '0);
        queue_req(OP_DELETE, k_max, '0);
        queue_req(OP_LIST,   '0, '0);

        // random part over a recurring key pool
        key_pool[0]  = 31'd1;
        key_pool[1]  = k_max;
        base_name[0] = '0;
        base_name[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i]  = KEY_W'($urandom);
            if (key_pool[i] == '0) begin
                key_pool[i] = 31'd2;
            end
            base_name[i] = {$urandom, $urandom};
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            req_pending.push_back(make_random_req(n / PHASE_LEN));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b0;
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // everything offered and taken, then every response back
        while (req_pending.size() != 0 || req_ch.valid) begin
            @(posedge i_clk);
        end
        while (rsp_expected.size() != 0) begin
            @(posedge i_clk);
        end
        // stray responses after the last expected one show up here
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests (add %0d, update %0d, delete %0d, search %0d, list %0d, other %0d)",
                 accepted, op_count[OP_ADD], op_count[OP_UPDATE], op_count[OP_DELETE],
                 op_count[OP_SEARCH], op_count[OP_LIST],
                 op_count[5] + op_count[6] + op_count[7]);
        $display("%0d responses, peak occupancy %0d of %0d, status codes seen %b, %0d errors",
                 responses, peak_count, DEPTH, status_seen, errors);
        if (errors == 0 && rsp_expected.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
